// ===== rtl/core/cnms_pkg.sv =====
// Shared types and constants of the Canny non-maximum suppression block.
package cnms_pkg;

    // Sequencer states of the per-word flow.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SQRT,
        ST_OUT
    } state_t;

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 13;
    localparam int WIDTH_FIELD   = 12;
    localparam int HEIGHT_FIELD  = 13;
    localparam int ROW_BITS      = 13;
    localparam int CMP_BITS      = 14;
    localparam int MAX_HEIGHT    = 4096;
    localparam int RESET_HEIGHT  = 480;
    localparam int MIN_DIM       = 3;

    localparam int MAG_BITS      = 11;
    localparam int M_TDATA_BITS  = 16;

    // tan(22.5) and tan(67.5) scaled by 2^16.
    localparam int TAN_SHIFT     = 16;
    localparam int TAN_LOW       = 27146;
    localparam int TAN_HIGH      = 158217;
    localparam int TAN_BITS      = 18;

    // Control from the sequencer to the root unit.
    typedef struct packed {
        logic start;
        logic clear;
    } sqrt_ctl_t;

endpackage

// ===== rtl/core/canny_direction_nms_window_top.sv =====
// Top level of the Canny non-maximum suppression stage with line-store memory.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata: grad_x, grad_y; tuser: is_pad
//  m_       | out       | m_tvalid/m_tready  | tdata: edge_magnitude; tlast: frame_end
//  cfg_     | in        | cfg_wr_en          | cfg_addr: register, cfg_wdata: value
//
// Each word passes the read, compare and output states after accept, and the root
// state between compare and output when the root is taken (an interior local
// maximum with a result due); the serial root unit takes one root bit per cycle.
// The line store is read at accept and written back in the next cycle, so one word is in flight at a time.
// Reset is synchronous; the line store is not cleared (never-written entries reach
// border pixels only). A stalled result waits in the output register and holds the
// sequencer in its last state until taken.
module canny_direction_nms_window_top #(
    parameter int MAX_WIDTH = 2048,
    parameter int GRAD_BITS = 11
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [GRAD_BITS-1:0] grad_x, [2*GRAD_BITS-1:GRAD_BITS] grad_y, zero fill above
    input  logic [((2*GRAD_BITS+7)/8)*8-1:0]     s_tdata,
    // [0] is_pad
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [10:0] edge_magnitude, zero fill above
    output logic [cnms_pkg::M_TDATA_BITS-1:0]    m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_wr_en,
    input  logic [cnms_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [cnms_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    localparam int G       = GRAD_BITS;
    localparam int SQ      = 2 * GRAD_BITS;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int ENTRY   = 3 * SQ;
    localparam int RESET_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int PB      = G + cnms_pkg::TAN_BITS;
    localparam int RB      = cnms_pkg::ROW_BITS;
    localparam int CB      = cnms_pkg::CMP_BITS;

    cnms_pkg::state_t state_reg, state_next;

    // line store: grad of middle row, square of middle row, square of upper row
    logic [ENTRY-1:0] line_mem [MAX_WIDTH];
    logic [ENTRY-1:0] rdata_reg;
    logic             mem_wr;
    logic [ENTRY-1:0] wdata;

    logic [WW-1:0]  image_width_reg;
    logic [RB-1:0]  image_height_reg;
    logic [CW-1:0]  column_count_reg;
    logic [RB-1:0]  row_count_reg;
    logic [G-1:0]   rx_reg, ry_reg;
    logic [SQ-1:0]  window_reg [9];
    logic [SQ-1:0]  center_grad_reg;
    logic           emit_reg, interior_reg, last_reg, diag_pos_reg;
    logic [PB-1:0]  p_low_reg, p_high_reg, ay_sh_reg;
    logic [G-1:0]   mag_reg;
    logic           m_tvalid_reg;
    logic [cnms_pkg::MAG_BITS-1:0] m_mag_reg;
    logic           m_tlast_reg;

    logic           in_fire, out_load, hit;
    cnms_pkg::sqrt_ctl_t sqrt_ctl;
    logic           sqrt_done;
    logic [G-1:0]   sqrt_root;

    // read-path values for the word in flight
    logic signed [G-1:0]  dx, dy, cx, cy;
    logic signed [SQ-1:0] dx2, dy2;
    logic [SQ-1:0]  sq;
    logic [G-1:0]   ax, ay;
    logic [SQ-1:0]  upper_sq, middle_sq, mid_grad;
    logic [SQ-1:0]  nb_a, nb_b;
    logic [RB-1:0]  ro;
    logic [WW-1:0]  co;
    logic           emit_w, interior_w, last_w, wrap_frame;
    logic [CB-1:0]  col_inc;
    logic [CB-1:0]  wcfg, hcfg;

    assign in_fire = s_tvalid && s_tready;

    // --- line store, read at accept, written back in ST_READ
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rdata_reg <= line_mem[column_count_reg];
        end
        if (mem_wr) begin
            line_mem[column_count_reg] <= wdata;
        end
    end

    assign upper_sq  = rdata_reg[SQ-1:0];
    assign middle_sq = rdata_reg[2*SQ-1:SQ];
    assign mid_grad  = rdata_reg[3*SQ-1:2*SQ];

    assign dx  = $signed(rx_reg);
    assign dy  = $signed(ry_reg);
    assign dx2 = SQ'(dx * dx);
    assign dy2 = SQ'(dy * dy);
    assign sq  = $unsigned(dx2) + $unsigned(dy2);
    assign wdata = {ry_reg, rx_reg, sq, middle_sq};

    // direction of the held center: magnitudes of its gradients
    assign cx = $signed(center_grad_reg[G-1:0]);
    assign cy = $signed(center_grad_reg[SQ-1:G]);
    assign ax = cx[G-1] ? G'(-cx) : G'(cx);
    assign ay = cy[G-1] ? G'(-cy) : G'(cy);

    // position of the result pixel
    always_comb begin
        emit_w = (row_count_reg >= RB'(2)) ||
                 (row_count_reg == RB'(1) && column_count_reg != '0);
        if (column_count_reg != '0) begin
            ro = row_count_reg - RB'(1);
            co = WW'(column_count_reg) - WW'(1);
        end else begin
            ro = row_count_reg - RB'(2);
            co = image_width_reg - WW'(1);
        end
        interior_w = (ro >= RB'(1)) && (CB'(ro) + CB'(2) <= CB'(image_height_reg)) &&
                     (co >= WW'(1)) && (CB'(co) + CB'(2) <= CB'(image_width_reg));
        last_w     = (CB'(ro) == CB'(image_height_reg) - CB'(1)) &&
                     (CB'(co) == CB'(image_width_reg) - CB'(1));
        wrap_frame = (CB'(row_count_reg) >= CB'(image_height_reg) + CB'(1)) &&
                     (column_count_reg == '0);
        col_inc    = CB'(column_count_reg) + CB'(1);
    end

    // neighbors along the bin
    always_comb begin
        priority if (ay_sh_reg < p_low_reg) begin
            nb_a = window_reg[3];
            nb_b = window_reg[5];
        end else if (ay_sh_reg >= p_high_reg) begin
            nb_a = window_reg[1];
            nb_b = window_reg[7];
        end else if (diag_pos_reg) begin
            nb_a = window_reg[0];
            nb_b = window_reg[8];
        end else begin
            nb_a = window_reg[2];
            nb_b = window_reg[6];
        end
        hit = emit_reg && interior_reg &&
              (window_reg[4] > nb_a) && (window_reg[4] > nb_b);
    end

    // clamped configuration values
    always_comb begin
        wcfg = CB'(cfg_wdata[cnms_pkg::WIDTH_FIELD-1:0]);
        if (wcfg < CB'(cnms_pkg::MIN_DIM)) begin
            wcfg = CB'(cnms_pkg::MIN_DIM);
        end else if (wcfg > CB'(MAX_WIDTH)) begin
            wcfg = CB'(MAX_WIDTH);
        end
        hcfg = CB'(cfg_wdata[cnms_pkg::HEIGHT_FIELD-1:0]);
        if (hcfg < CB'(cnms_pkg::MIN_DIM)) begin
            hcfg = CB'(cnms_pkg::MIN_DIM);
        end else if (hcfg > CB'(cnms_pkg::MAX_HEIGHT)) begin
            hcfg = CB'(cnms_pkg::MAX_HEIGHT);
        end
    end

    // --- sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cnms_pkg::ST_IDLE: if (in_fire) state_next = cnms_pkg::ST_READ;
            cnms_pkg::ST_READ: state_next = cnms_pkg::ST_CMP;
            cnms_pkg::ST_CMP:  state_next = hit ? cnms_pkg::ST_SQRT : cnms_pkg::ST_OUT;
            cnms_pkg::ST_SQRT: if (sqrt_done) state_next = cnms_pkg::ST_OUT;
            cnms_pkg::ST_OUT: begin
                if (!emit_reg || !m_tvalid_reg || m_tready) begin
                    state_next = cnms_pkg::ST_IDLE;
                end
            end
            default: state_next = cnms_pkg::ST_IDLE;
        endcase
    end

    // --- sequencer: outputs
    always_comb begin
        s_tready       = 1'b0;
        mem_wr         = 1'b0;
        sqrt_ctl.start = 1'b0;
        sqrt_ctl.clear = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            cnms_pkg::ST_IDLE: s_tready = 1'b1;
            cnms_pkg::ST_READ: mem_wr = 1'b1;
            cnms_pkg::ST_CMP:  sqrt_ctl.start = hit;
            cnms_pkg::ST_SQRT: sqrt_ctl.clear = 1'b0;
            cnms_pkg::ST_OUT:  out_load = emit_reg && (!m_tvalid_reg || m_tready);
            default: sqrt_ctl.clear = 1'b1;
        endcase
    end

    cnms_isqrt #(
        .ROOT_BITS (G)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (sqrt_ctl),
        .radicand (window_reg[4]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // --- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= cnms_pkg::ST_IDLE;
            image_width_reg  <= WW'(RESET_W);
            image_height_reg <= RB'(cnms_pkg::RESET_HEIGHT);
            column_count_reg <= '0;
            row_count_reg    <= '0;
            center_grad_reg  <= '0;
            m_tvalid_reg     <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                // any write restarts the frame
                unique case (cfg_addr)
                    cnms_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= WW'(wcfg);
                    cnms_pkg::REG_IMAGE_HEIGHT: image_height_reg <= RB'(hcfg);
                    default: image_width_reg <= image_width_reg;
                endcase
                column_count_reg <= '0;
                row_count_reg    <= '0;
                center_grad_reg  <= '0;
                for (int i = 0; i < 9; i++) begin
                    window_reg[i] <= '0;
                end
            end else if (state_reg == cnms_pkg::ST_READ) begin
                // shift the window left and load the new right column
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= upper_sq;
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[5] <= middle_sq;
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[8] <= sq;
                center_grad_reg <= mid_grad;
                // advance the raster position
                if (wrap_frame) begin
                    column_count_reg <= '0;
                    row_count_reg    <= '0;
                end else if (col_inc >= CB'(image_width_reg)) begin
                    column_count_reg <= '0;
                    row_count_reg    <= row_count_reg + RB'(1);
                end else begin
                    column_count_reg <= CW'(col_inc);
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // --- payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            // drop the gradients of a flush word
            rx_reg <= s_tuser ? '0 : s_tdata[G-1:0];
            ry_reg <= s_tuser ? '0 : s_tdata[SQ-1:G];
        end
        if (state_reg == cnms_pkg::ST_READ) begin
            emit_reg     <= emit_w;
            interior_reg <= interior_w;
            last_reg     <= last_w;
            diag_pos_reg <= (cx[G-1] == cy[G-1]);
            p_low_reg    <= PB'(ax) * PB'(cnms_pkg::TAN_LOW);
            p_high_reg   <= PB'(ax) * PB'(cnms_pkg::TAN_HIGH);
            ay_sh_reg    <= PB'(ay) << cnms_pkg::TAN_SHIFT;
        end
        if (state_reg == cnms_pkg::ST_CMP) begin
            mag_reg <= '0;
        end else if (sqrt_done) begin
            mag_reg <= sqrt_root;
        end
        if (out_load) begin
            m_mag_reg   <= cnms_pkg::MAG_BITS'(mag_reg);
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cnms_pkg::M_TDATA_BITS'(m_mag_reg);
    assign m_tlast  = m_tlast_reg;

    a_accept_read : assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !cfg_wr_en |=> state_reg == cnms_pkg::ST_READ)
        else $error("accepted word did not reach the read state");
    a_col_range : assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(column_count_reg) < image_width_reg)
        else $error("column count beyond image width");
    a_root_state : assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == cnms_pkg::ST_SQRT)
        else $error("root finished outside its state");
    a_load_state : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == cnms_pkg::ST_OUT)
        else $error("result loaded outside the output state");

endmodule

// ===== rtl/core/cnms_isqrt.sv =====
// Bit-pair iterative integer square root, one result bit per cycle.
module cnms_isqrt #(
    parameter int ROOT_BITS = 11
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cnms_pkg::sqrt_ctl_t      ctl,
    input  logic [2*ROOT_BITS-1:0]   radicand,
    output logic                     done,
    output logic [ROOT_BITS-1:0]     root
);
    localparam int SQ_BITS = 2 * ROOT_BITS;

    logic [SQ_BITS-1:0] rem_reg,  rem_next;
    logic [SQ_BITS-1:0] res_reg,  res_next;
    logic [SQ_BITS-1:0] bit_reg,  bit_next;
    logic               busy_reg, busy_next;
    logic [SQ_BITS:0]   trial;

    always_comb begin
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (ctl.start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = SQ_BITS'(1) << (SQ_BITS - 2);
            busy_next = 1'b1;
        end else if (ctl.clear) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            // take the bit where the remainder allows it
            if ({1'b0, rem_reg} >= trial) begin
                rem_next = rem_reg - trial[SQ_BITS-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_next == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = busy_reg && (bit_reg == SQ_BITS'(1));
    assign root = ROOT_BITS'(done ? res_next : res_reg);

    a_done_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !busy_reg || $past(ctl.start))
        else $error("root unit stayed busy after done");
    a_start_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> busy_reg)
        else $error("root unit did not start");
    a_bit_pow4 : assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot(bit_reg))
        else $error("root unit trial bit corrupt");

endmodule
